// File: rtl/core/rtpm_pkg.sv
// Shared types, codes and helpers for the request tag pool.
// No dependencies; imported by every module of the block.
`default_nettype none

package rtpm_pkg;

    // Item kinds carried on the input tuser
    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Result status codes carried on the output tuser
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    // Busy bits are kept as rows of this many tags
    localparam int ROW_BITS = 16;
    localparam int BIT_W    = 4;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] in_use;
        logic [7:0] owner;
        logic [7:0] tag;
    } rtpm_result_t;

    // Position of the lowest clear bit of a row (row must not be all ones)
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [ROW_BITS-1:0] word);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rtpm_out_buf.sv
// Output register with one skid entry for the tag pool results.
// Depends on rtpm_pkg for the result type.
`default_nettype none

module rtpm_out_buf
    import rtpm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire rtpm_result_t in_data,
    output logic              skid_full,
    output logic              out_valid,
    input  wire logic         out_ready,
    output rtpm_result_t      out_data
);

    logic         out_valid_reg;
    logic         skid_valid_reg;
    rtpm_result_t out_data_reg;
    rtpm_result_t skid_data_reg;
    logic         out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign skid_full = skid_valid_reg;

    // Control: refill the output from skid first, park new results when stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= skid_valid_reg && in_valid;
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
            if (in_valid)
            begin
                skid_data_reg <= in_data;
            end
        end
        else if (in_valid)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/request_tag_pool_with_reply_match.sv
// Top level of the request tag pool with reply matching.
// Depends on rtpm_pkg and rtpm_out_buf.
//
// Usage:
//   Input channel s_*: one transaction per request. s_tuser is the kind
//   (allocate, release, reply, or an ignored code); s_tdata carries the tag
//   and the owner id. Output channel m_*: one result per request with the
//   status on m_tuser and the tag, matched owner and in-use count on m_tdata.
//   Busy bits live in a one-port-read, one-port-write memory of 16-tag rows,
//   owners in a second memory indexed by tag. A request issues its reads in
//   the accept cycle and commits its read-modify-write in the next one, so
//   the input takes no new request while one is in its commit cycle;
//   m_tvalid rises once the result has passed st_valid_reg and the output
//   register.
//   A small per-row full summary picks the row for an allocate.
//   Reset clears all row-valid and row-full flags at once, so every tag
//   reads free immediately; no clearing pass runs. Owner entries are only
//   used for busy tags. When m_tready is low, results wait in an output
//   register and one skid entry; the input keeps accepting until the skid
//   entry is occupied.
`default_nettype none

module request_tag_pool_with_reply_match
    import rtpm_pkg::*;
#(
    parameter int NUM_TAGS   = 256,
    parameter int OWNER_BITS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] tag, [15:8] owner
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] granted_tag, [15:8] matched_owner,
                                        // [24:16] in_use, [31:25] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    localparam int TAG_W     = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
    localparam int ROWS      = (NUM_TAGS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W     = $clog2(NUM_TAGS + 1);
    localparam int LAST_BITS = NUM_TAGS - (ROWS - 1) * ROW_BITS;
    localparam logic [ROW_BITS-1:0] LAST_PAD =
        ROW_BITS'(~((33'd1 << LAST_BITS) - 33'd1));

    // Storage
    logic [ROW_BITS-1:0]   busy_mem  [ROWS];
    logic [OWNER_BITS-1:0] owner_mem [NUM_TAGS];
    logic [ROW_BITS-1:0]   busy_q_reg;
    logic [OWNER_BITS-1:0] owner_q_reg;
    logic [ROWS-1:0]       row_valid_reg;
    logic [ROWS-1:0]       row_full_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // Request held between the read and commit cycles
    logic                  st_valid_reg;
    logic [1:0]            st_kind_reg;
    logic [7:0]            st_tag_reg;
    logic [ROW_W-1:0]      st_row_reg;
    logic [BIT_W-1:0]      st_bit_reg;
    logic [OWNER_BITS-1:0] st_owner_reg;
    logic                  st_tag_ok_reg;
    logic                  st_full_reg;

    // Accept-side decode
    logic                  accept;
    logic                  skid_full;
    logic [7:0]            in_tag;
    logic [TAG_W-1:0]      in_idx;
    logic [ROW_W-1:0]      in_row;
    logic [ROW_W-1:0]      alloc_row;
    logic                  all_full;
    logic [ROW_W-1:0]      rd_row;

    // Commit-side logic
    logic [ROW_BITS-1:0]   row_word;
    logic [ROW_BITS-1:0]   row_pad;
    logic [BIT_W-1:0]      free_bit;
    logic [TAG_W-1:0]      alloc_idx;
    logic                  tag_busy;
    logic                  wr_busy;
    logic [ROW_BITS-1:0]   wr_word;
    logic                  wr_owner;
    rtpm_result_t          res;
    rtpm_result_t          out_res;

    assign s_tready = !st_valid_reg && !skid_full;
    assign accept   = s_tvalid && s_tready;
    assign in_tag   = s_tdata[7:0];
    assign in_idx   = TAG_W'(in_tag);
    assign in_row   = ROW_W'(in_idx >> BIT_W);
    assign all_full = &row_full_reg;

    // Pick the lowest row that still has a free tag
    always_comb
    begin
        alloc_row = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (!row_full_reg[r]) begin
                alloc_row = ROW_W'(r);
            end
        end
    end

    assign rd_row = (s_tuser == KIND_ALLOC) ? alloc_row : in_row;

    // Read both memories in the accept cycle; write back busy rows and owners on commit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            busy_q_reg  <= busy_mem[rd_row];
            owner_q_reg <= owner_mem[in_idx];
        end
        if (wr_busy)
        begin
            busy_mem[st_row_reg] <= wr_word;
        end
        if (wr_owner)
        begin
            owner_mem[alloc_idx] <= st_owner_reg;
        end
    end

    // Hold the request for the commit cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_kind_reg   <= s_tuser;
            st_tag_reg    <= in_tag;
            st_row_reg    <= rd_row;
            st_bit_reg    <= BIT_W'(in_idx);
            st_owner_reg  <= OWNER_BITS'(s_tdata[15:8]);
            st_tag_ok_reg <= ({24'd0, in_tag} < 32'(NUM_TAGS));
            st_full_reg   <= all_full;
        end
    end

    // Modify: decode the read row and build the result
    assign row_word  = row_valid_reg[st_row_reg] ? busy_q_reg : '0;
    assign row_pad   = (st_row_reg == ROW_W'(ROWS - 1)) ? LAST_PAD : '0;
    assign free_bit  = lowest_zero(row_word | row_pad);
    assign alloc_idx = TAG_W'({st_row_reg, free_bit});
    assign tag_busy  = st_tag_ok_reg && row_word[st_bit_reg];

    always_comb
    begin
        wr_busy    = 1'b0;
        wr_owner   = 1'b0;
        wr_word    = row_word;
        count_next = count_reg;
        res.status = ST_OK;
        res.tag    = '0;
        res.owner  = '0;
        case (st_kind_reg)
            KIND_ALLOC:
            begin
                if (st_full_reg)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    wr_busy            = 1'b1;
                    wr_owner           = 1'b1;
                    wr_word[free_bit]  = 1'b1;
                    count_next         = count_reg + CNT_W'(1);
                    res.tag            = 8'(alloc_idx);
                end
            end
            KIND_RELEASE, KIND_REPLY:
            begin
                res.tag = st_tag_reg;
                if (!tag_busy)
                begin
                    res.status = ST_UNKNOWN;
                end
                else
                begin
                    res.owner = 8'(owner_q_reg);
                    if (st_kind_reg == KIND_RELEASE)
                    begin
                        wr_busy             = 1'b1;
                        wr_word[st_bit_reg] = 1'b0;
                        count_next          = count_reg - CNT_W'(1);
                        if (owner_q_reg != st_owner_reg)
                        begin
                            res.status = ST_MISMATCH;
                        end
                    end
                end
            end
            default:
            begin
                res.status = ST_OK;
            end
        endcase
        res.in_use = 9'(count_next);
        if (!st_valid_reg)
        begin
            wr_busy    = 1'b0;
            wr_owner   = 1'b0;
            count_next = count_reg;
        end
    end

    // Write back the count and row summary flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            row_valid_reg <= '0;
            row_full_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_busy)
            begin
                row_valid_reg[st_row_reg] <= 1'b1;
                row_full_reg[st_row_reg]  <= &(wr_word | row_pad);
            end
        end
    end

    rtpm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid_reg),
        .in_data   (res),
        .skid_full (skid_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {7'd0, out_res.in_use, out_res.owner, out_res.tag};
    assign m_tuser = out_res.status;

endmodule

`default_nettype wire

// File: rtl/core/rtpm_checker.sv
// Port-level checks for the request tag pool, bound to the top level.
// Depends on rtpm_pkg for status codes.
`default_nettype none

module rtpm_checker
    import rtpm_pkg::*;
#(
    parameter int NUM_TAGS = 256
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One request in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // Full pool means every tag counted in use
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_FULL |-> m_tdata[24:16] == 9'(NUM_TAGS))
        else $error("pool full with wrong in-use count");

    // Unknown tag never reports an owner
    a_unknown_owner: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_UNKNOWN |-> m_tdata[15:8] == 8'd0)
        else $error("unknown tag with owner");

    // In-use count stays within the pool
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (NUM_TAGS > 511) || ({23'd0, m_tdata[24:16]} <= 32'(NUM_TAGS)))
        else $error("in-use count beyond pool size");

endmodule

bind request_tag_pool_with_reply_match rtpm_checker #(.NUM_TAGS(NUM_TAGS)) u_rtpm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
